/* rtl/first_fit_block_allocator_core_assert.svh */
// assertion macros shared by the allocator checker
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define FBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fba assertion failed");

// next-cycle implication, disabled while reset is active
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fba assertion failed");

`endif

/* rtl/fba_pkg.sv */
// shared types and constants for the first-fit block allocator
package fba_pkg;

    localparam int FIELD_W   = 20;
    localparam int LIMIT_W   = 21;
    localparam int HEADER_W  = 8;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 1'b1;

    localparam logic [LIMIT_W-1:0]  HEAP_LIMIT_RST   = 21'd1048576;
    localparam logic [HEADER_W-1:0] HEADER_BYTES_RST = 8'd24;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } fba_kind_t;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_ZERO_SIZE      = 3'd1,
        ST_HEAP_EXHAUSTED = 3'd2,
        ST_TABLE_FULL     = 3'd3,
        ST_UNKNOWN_FREE   = 3'd4
    } fba_status_t;

    typedef struct packed {
        fba_kind_t          kind;
        logic [FIELD_W-1:0] request_size;
        logic [FIELD_W-1:0] release_address;
    } fba_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] data_address;
        fba_status_t        status;
    } fba_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_FINISH
    } fba_state_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_NULL,
        RES_HIT,
        RES_UNKNOWN,
        RES_APPEND
    } fba_res_t;

    typedef struct packed {
        logic     capture;
        logic     scan;
        logic     res_load;
        fba_res_t res_sel;
        logic     push;
    } fba_cmd_t;

    typedef struct packed {
        logic zero_req;
        logic null_free;
        logic free_op;
        logic hit;
        logic scan_done;
        logic out_busy;
    } fba_stat_t;

endpackage

/* rtl/fba_ctrl.sv */
// controller state machine for the first-fit block allocator
module fba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fba_pkg::fba_stat_t stat,
    output fba_pkg::fba_cmd_t  cmd
);
    import fba_pkg::*;

    fba_state_t state_reg;
    fba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.zero_req || stat.null_free || stat.hit)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.scan_done)
                begin
                    state_next = stat.free_op ? S_FINISH : S_APPEND;
                end
            end
            S_APPEND:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.res_sel  = RES_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.zero_req)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ZERO;
                end
                else if (stat.null_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_NULL;
                end
                else if (stat.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_HIT;
                end
                else if (stat.scan_done && stat.free_op)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_UNKNOWN;
                end
            end
            S_APPEND:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_APPEND;
            end
            S_FINISH:
            begin
                cmd.push = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/fba_dp.sv */
// datapath of the first-fit block allocator: block table, heap top, result registers
module fba_dp #(
    parameter int MAX_BLOCKS = 64,
    parameter int ADDR_BITS  = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fba_pkg::CFG_W-1:0]           cfg_data,
    input  fba_pkg::fba_in_t                    in_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output fba_pkg::fba_out_t                   out_data,
    input  fba_pkg::fba_cmd_t                   cmd,
    output fba_pkg::fba_stat_t                  stat
);
    import fba_pkg::*;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int BASE_W  = (ADDR_BITS < LIMIT_W) ? ADDR_BITS : LIMIT_W;
    localparam int DA_W    = (ADDR_BITS < LIMIT_W + 1) ? ADDR_BITS : LIMIT_W + 1;
    localparam int CMP_W   = (DA_W > FIELD_W) ? DA_W : FIELD_W;
    localparam int ENTRY_W = 1 + FIELD_W + BASE_W;
    localparam int SUM_W   = LIMIT_W + 2;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);
    // address span, saturated where it lies above any heap_limit value
    localparam logic [LIMIT_W:0] SPAN_CAP = (ADDR_BITS > LIMIT_W) ?
        {(LIMIT_W + 1){1'b1}} : ((LIMIT_W + 1)'(1) << ADDR_BITS);

    // control registers
    logic [LIMIT_W-1:0]  heap_limit_reg, heap_limit_next;
    logic [HEADER_W-1:0] header_reg, header_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LIMIT_W-1:0]  heap_top_reg, heap_top_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                out_valid_reg, out_valid_next;

    // payload registers
    fba_in_t             req_reg, req_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    fba_out_t            res_reg, res_next;
    fba_out_t            out_reg, out_next;

    // block table
    logic [ENTRY_W-1:0]  table_mem [MAX_BLOCKS];
    logic [ENTRY_W-1:0]  rd_q;
    logic                rd_en;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;

    logic                q_free;
    logic [FIELD_W-1:0]  q_len;
    logic [BASE_W-1:0]   q_base;
    logic [SUM_W-1:0]    hit_sum;
    logic [DA_W-1:0]     hit_da;
    logic                match_alloc;
    logic                match_free;

    logic [SUM_W-1:0]    need;
    logic [LIMIT_W:0]    limit_ext;
    logic [LIMIT_W:0]    eff_limit;
    logic                exhausted;
    logic                full;
    logic [BASE_W-1:0]   new_base;
    logic [SUM_W-1:0]    new_sum;
    logic [DA_W-1:0]     new_da;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q <= table_mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign rd_en  = cmd.scan && (idx_reg < count_reg);
    assign q_free = rd_q[ENTRY_W-1];
    assign q_len  = rd_q[FIELD_W+BASE_W-1:BASE_W];
    assign q_base = rd_q[BASE_W-1:0];

    // data address of the entry under test, wrapped to the address span
    assign hit_sum     = SUM_W'(q_base) + SUM_W'(header_reg);
    assign hit_da      = hit_sum[DA_W-1:0];
    assign match_alloc = q_free && (q_len >= req_reg.request_size);
    assign match_free  = CMP_W'(hit_da) == CMP_W'(req_reg.release_address);

    // append check against the effective heap limit
    assign need      = SUM_W'(heap_top_reg) + SUM_W'(header_reg) + SUM_W'(req_reg.request_size);
    assign limit_ext = (LIMIT_W + 1)'(heap_limit_reg);
    assign eff_limit = (limit_ext < SPAN_CAP) ? limit_ext : SPAN_CAP;
    assign exhausted = need > SUM_W'(eff_limit);
    assign full      = count_reg >= MAX_CNT;
    assign new_base  = BASE_W'(heap_top_reg);
    assign new_sum   = SUM_W'(new_base) + SUM_W'(header_reg);
    assign new_da    = new_sum[DA_W-1:0];

    always_comb
    begin
        stat.zero_req  = (req_reg.kind == OP_ALLOC) && (req_reg.request_size == '0);
        stat.null_free = (req_reg.kind == OP_FREE) && (req_reg.release_address == '0);
        stat.free_op   = req_reg.kind == OP_FREE;
        stat.hit       = rd_valid_reg && ((req_reg.kind == OP_FREE) ? match_free : match_alloc);
        stat.scan_done = !rd_valid_reg && (idx_reg >= count_reg);
        stat.out_busy  = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        heap_limit_next = heap_limit_reg;
        header_next     = header_reg;
        count_next      = count_reg;
        heap_top_next   = heap_top_reg;
        idx_next        = idx_reg;
        rd_valid_next   = rd_en;
        rd_idx_next     = rd_idx_reg;
        req_next        = req_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_idx_reg;
        mem_wdata       = {stat.free_op, q_len, q_base};

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_HEAP_LIMIT:   heap_limit_next = cfg_data[LIMIT_W-1:0];
                CFG_HEADER_BYTES: header_next     = cfg_data[HEADER_W-1:0];
                default:          header_next     = header_reg;
            endcase
        end

        if (cmd.capture)
        begin
            req_next      = in_data;
            idx_next      = '0;
            rd_valid_next = 1'b0;
        end
        else if (rd_en)
        begin
            idx_next    = idx_reg + CNT_W'(1);
            rd_idx_next = idx_reg[IDX_W-1:0];
        end

        if (cmd.res_load)
        begin
            res_next.data_address = '0;
            res_next.status       = ST_OK;
            case (cmd.res_sel)
                RES_ZERO:    res_next.status = ST_ZERO_SIZE;
                RES_NULL:    res_next.status = ST_OK;
                RES_HIT:
                begin
                    // mark used on allocate, free on release; length and base kept
                    mem_we = 1'b1;
                    if (!stat.free_op)
                    begin
                        res_next.data_address = FIELD_W'(hit_da);
                    end
                end
                RES_UNKNOWN: res_next.status = ST_UNKNOWN_FREE;
                RES_APPEND:
                begin
                    if (exhausted)
                    begin
                        res_next.status = ST_HEAP_EXHAUSTED;
                    end
                    else if (full)
                    begin
                        res_next.status = ST_TABLE_FULL;
                    end
                    else
                    begin
                        mem_we                = 1'b1;
                        mem_waddr             = count_reg[IDX_W-1:0];
                        mem_wdata             = {1'b0, req_reg.request_size, new_base};
                        count_next            = count_reg + CNT_W'(1);
                        heap_top_next         = need[LIMIT_W-1:0];
                        res_next.data_address = FIELD_W'(new_da);
                    end
                end
                default:     res_next.status = ST_OK;
            endcase
        end

        if (cmd.push)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= HEAP_LIMIT_RST;
            header_reg     <= HEADER_BYTES_RST;
            count_reg      <= '0;
            heap_top_reg   <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            heap_limit_reg <= heap_limit_next;
            header_reg     <= header_next;
            count_reg      <= count_next;
            heap_top_reg   <= heap_top_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rd_idx_reg <= rd_idx_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/first_fit_block_allocator_core.sv */
// top level of the first-fit block allocator
//
// usage:
//   input channel in_valid/in_ready/in_data carries one request per transaction:
//   kind selects allocate or free, request_size and release_address are the operands
//   output channel out_valid/out_ready/out_data returns exactly one result per request:
//   data_address (0 unless an allocate succeeded) and a status code
//   cfg_write/cfg_index/cfg_data set heap_limit (index 0) and header_bytes (index 1);
//   write them only while no request is in flight
// timing:
//   one request at a time; the table is scanned one entry per cycle through the
//   registered read port of the block table memory
//   a hit ends the scan at the matching entry; a miss scans every entry, then an
//   allocate goes through the append check before the output load
//   zero-size allocates and null frees end the scan before any entry is checked
// reset:
//   rst_n clears the block count, heap top and handshake state and restores the
//   register defaults; table contents are not cleared, entries past the count are unused
// back-pressure:
//   a result waits in the output register while out_ready is low; the next request
//   is still accepted, but its result waits until the previous one is taken
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = 64,
    parameter int ADDR_BITS  = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fba_pkg::fba_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fba_pkg::fba_out_t             out_data,
    input  logic                          cfg_write,
    input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fba_pkg::CFG_W-1:0]     cfg_data
);
    import fba_pkg::*;

    // command and status between sequencer and datapath
    fba_cmd_t  cmd;
    fba_stat_t stat;

    // sequencer: idle, scan, append check, output load
    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // block table, heap top, config registers and output register
    fba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* rtl/fba_checker.sv */
// port-level checker for the first-fit block allocator, bound to the top level
`include "first_fit_block_allocator_core_assert.svh"

module fba_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input fba_pkg::fba_out_t out_data
);
    import fba_pkg::*;

    // a stalled result holds
    `FBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // failed requests never carry an address
    `FBA_ASSERT_NOW(a_fail_no_addr, clk, rst_n, out_valid && (out_data.status != ST_OK), out_data.data_address == '0)

    // one request at a time: ready drops right after a transaction
    `FBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    // no result can appear in the cycle right after a request is taken
    `FBA_ASSERT_NEXT(a_min_latency, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind first_fit_block_allocator_core fba_checker u_fba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
